// ----- hw/rtl/chull_pkg.sv -----
package chull_pkg;

	localparam int MAX_POINTS  = 32;
	localparam int CNT_W       = $clog2(MAX_POINTS + 1);
	localparam int IDX_W       = $clog2(MAX_POINTS);
	localparam int STACK_DEPTH = 2 * MAX_POINTS;
	localparam int SADDR_W     = $clog2(STACK_DEPTH);
	localparam int H_W         = $clog2(STACK_DEPTH + 1);

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} point_t;

	typedef struct packed {
		logic ins;
		logic start;
		logic cr1;
		logic cr2;
		logic push;
		logic pop;
		logic fetch;
		logic k_inc;
		logic k_dec;
		logic go_upper;
		logic finish;
		logic rd_emit;
		logic emit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic m_zero;
		logic m_ge2;
		logic pop_ok;
		logic nonpos;
		logic upper;
		logic k_last;
		logic k_zero;
		logic out_free;
		logic e_last;
		logic full;
		logic ovf;
	} sts_t;

	function automatic logic pt_less(point_t a, point_t b);
		return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
	endfunction

endpackage

// ----- hw/rtl/chull_ctrl.sv -----
module chull_ctrl
	import chull_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic point_valid,
	input  logic set_last,
	output logic point_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_LOAD, S_START, S_CHECK, S_CR1, S_CR2, S_CR3, S_PUSH, S_POP, S_FETCH,
		S_FINISH, S_ERD, S_EWR, S_DONE
	} state_t;

	state_t state_q;

	assign point_ready = (state_q == S_LOAD);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_LOAD:   cmd.ins = point_valid;
			S_START:  cmd.start = !sts.m_zero;
			S_CR1:    cmd.cr1 = 1'b1;
			S_CR2:    cmd.cr2 = 1'b1;
			S_PUSH: begin
				cmd.push = 1'b1;
				if (sts.upper) begin
					cmd.k_dec = !sts.k_zero;
				end else if (sts.k_last) begin
					cmd.go_upper = sts.m_ge2;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			S_POP:    cmd.pop = 1'b1;
			S_FETCH:  cmd.fetch = 1'b1;
			S_FINISH: cmd.finish = 1'b1;
			S_ERD:    cmd.rd_emit = 1'b1;
			S_EWR:    cmd.emit = sts.out_free;
			S_DONE:   cmd.clear = 1'b1;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD:   if (point_valid && set_last) state_q <= S_START;
				S_START:  state_q <= sts.m_zero ? S_DONE : S_CHECK;
				S_CHECK:  state_q <= sts.pop_ok ? S_CR1 : S_PUSH;
				S_CR1:    state_q <= S_CR2;
				S_CR2:    state_q <= S_CR3;
				S_CR3:    state_q <= sts.nonpos ? S_POP : S_PUSH;
				S_POP:    state_q <= S_FETCH;
				S_FETCH:  state_q <= S_CHECK;
				S_PUSH: begin
					if (sts.upper) begin
						state_q <= sts.k_zero ? S_FINISH : S_CHECK;
					end else if (sts.k_last) begin
						state_q <= sts.m_ge2 ? S_CHECK : S_FINISH;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_FINISH: state_q <= S_ERD;
				S_ERD:    state_q <= S_EWR;
				S_EWR:    if (sts.out_free) state_q <= sts.e_last ? S_DONE : S_ERD;
				S_DONE:   state_q <= S_LOAD;
				default:  state_q <= S_LOAD;
			endcase
		end
	end

endmodule

// ----- hw/rtl/chull_dp.sv -----
module chull_dp
	import chull_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	output logic               vertex_valid,
	input  logic               vertex_ready,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic               vertex_last,
	output logic               points_dropped
);

	point_t             srt_q [MAX_POINTS];
	point_t             srt_nx [MAX_POINTS];
	logic [MAX_POINTS-1:0] ge;
	logic [MAX_POINTS-1:0] eq;
	logic [CNT_W-1:0]   raw_q;
	logic [CNT_W-1:0]   m_q;
	logic               ovf_q;
	point_t             pin;
	logic               dup;

	logic [63:0]        stk_mem [STACK_DEPTH];
	logic [63:0]        rd_q;
	logic [SADDR_W-1:0] rd_addr;
	point_t             t1_q;
	point_t             t2_q;
	logic [H_W-1:0]     h_q;
	logic [H_W-1:0]     t_q;
	logic [H_W-1:0]     h_fin;
	logic [IDX_W-1:0]   k_q;
	logic               upper_q;
	logic [SADDR_W-1:0] e_q;
	point_t             wk;

	logic signed [32:0] dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [65:0] p_s2, q_s2;
	logic signed [66:0] d;

	logic               ov_q;
	point_t             ov_pt_q;
	logic               ov_last_q;
	logic               ov_drop_q;

	assign pin.x = point_x;
	assign pin.y = point_y;
	assign wk    = srt_q[k_q];

	always_comb begin
		for (int i = 0; i < MAX_POINTS; i++) begin
			ge[i] = (CNT_W'(i) < m_q) && !pt_less(pin, srt_q[i]);
			eq[i] = (CNT_W'(i) < m_q) && (srt_q[i] == pin);
		end
		dup = |eq;
		for (int i = 0; i < MAX_POINTS; i++) begin
			if (ge[i]) begin
				srt_nx[i] = srt_q[i];
			end else if (i == 0) begin
				srt_nx[i] = pin;
			end else if (ge[i-1]) begin
				srt_nx[i] = pin;
			end else begin
				srt_nx[i] = srt_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && (raw_q < CNT_W'(MAX_POINTS)) && !dup) begin
			for (int i = 0; i < MAX_POINTS; i++) srt_q[i] <= srt_nx[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= '0;
			m_q   <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.clear) begin
			raw_q <= '0;
			m_q   <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.ins) begin
			if (raw_q < CNT_W'(MAX_POINTS)) begin
				raw_q <= raw_q + 1'b1;
				if (!dup) m_q <= m_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_comb begin
		if (cmd.pop) begin
			rd_addr = SADDR_W'(h_q - H_W'(3));
		end else begin
			rd_addr = e_q;
		end
	end

	always_comb begin
		h_fin = (h_q > H_W'(1)) ? h_q - 1'b1 : h_q;
		if (h_fin > H_W'(MAX_POINTS)) h_fin = H_W'(MAX_POINTS);
	end

	always_ff @(posedge clk) begin
		if (cmd.push) stk_mem[h_q[SADDR_W-1:0]] <= wk;
		if (cmd.pop || cmd.rd_emit) rd_q <= stk_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			t2_q <= t1_q;
			t1_q <= wk;
		end else if (cmd.pop) begin
			t1_q <= t2_q;
		end else if (cmd.fetch) begin
			t2_q <= rd_q;
		end
		if (cmd.cr1) begin
			dax_s1 <= 33'(t1_q.x) - 33'(t2_q.x);
			day_s1 <= 33'(t1_q.y) - 33'(t2_q.y);
			dbx_s1 <= 33'(wk.x) - 33'(t2_q.x);
			dby_s1 <= 33'(wk.y) - 33'(t2_q.y);
		end
		if (cmd.cr2) begin
			p_s2 <= dax_s1 * dby_s1;
			q_s2 <= day_s1 * dbx_s1;
		end
	end

	assign d = 67'(p_s2) - 67'(q_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= '0;
			t_q     <= '0;
			k_q     <= '0;
			upper_q <= 1'b0;
			e_q     <= '0;
		end else begin
			if (cmd.start) begin
				h_q     <= '0;
				k_q     <= '0;
				upper_q <= 1'b0;
			end else if (cmd.push) begin
				h_q <= h_q + 1'b1;
			end else if (cmd.pop) begin
				h_q <= h_q - 1'b1;
			end else if (cmd.finish) begin
				h_q <= h_fin;
				e_q <= '0;
			end
			if (cmd.k_inc) k_q <= k_q + 1'b1;
			if (cmd.k_dec) k_q <= k_q - 1'b1;
			if (cmd.go_upper) begin
				upper_q <= 1'b1;
				k_q     <= IDX_W'(m_q - CNT_W'(2));
				t_q     <= h_q + H_W'(2);
			end
			if (cmd.emit) e_q <= e_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (vertex_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ov_pt_q   <= rd_q;
			ov_last_q <= (H_W'(e_q) == h_q - 1'b1);
			ov_drop_q <= ovf_q;
		end
	end

	assign vertex_valid   = ov_q;
	assign vertex_x       = ov_pt_q.x;
	assign vertex_y       = ov_pt_q.y;
	assign vertex_last    = ov_last_q;
	assign points_dropped = ov_drop_q;

	always_comb begin
		sts.m_zero   = (m_q == '0);
		sts.m_ge2    = (m_q >= CNT_W'(2));
		sts.pop_ok   = upper_q ? (h_q >= t_q) : (h_q >= H_W'(2));
		sts.nonpos   = d[66] || (d == '0);
		sts.upper    = upper_q;
		sts.k_last   = (CNT_W'(k_q) == m_q - 1'b1);
		sts.k_zero   = (k_q == '0);
		sts.out_free = !ov_q || vertex_ready;
		sts.e_last   = (H_W'(e_q) == h_q - 1'b1);
		sts.full     = (raw_q >= CNT_W'(MAX_POINTS));
		sts.ovf      = ovf_q;
	end

endmodule

// ----- hw/rtl/convex_hull_monotone_chain_unit.sv -----
// channel   valid          ready          payload
// point     point_valid    point_ready    point_x, point_y, set_last
// vertex    vertex_valid   vertex_ready   vertex_x, vertex_y, vertex_last, points_dropped
//
// Points load one per cycle while point_ready is high into a sorted insertion list; duplicates are merged on entry.
// After set_last the hull scan checks the stack, runs cross product tests in steps CR1, CR2, CR3 and
// pushes or pops (pop, then fetch), using the shared cross product unit and the stack port.
// Each vertex is a stack memory read, then an output register load.
// Reset clears counts and control; the stored points need no clearing.
// A stalled vertex holds the vertex sequence; no point is taken until the run ends.
module convex_hull_monotone_chain_unit
	import chull_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               point_valid,
	output logic               point_ready,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic               set_last,
	output logic               vertex_valid,
	input  logic               vertex_ready,
	output logic signed [31:0] vertex_x,
	output logic signed [31:0] vertex_y,
	output logic               vertex_last,
	output logic               points_dropped
);

	cmd_t cmd;
	sts_t sts;

	chull_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.set_last    (set_last),
		.point_ready (point_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	chull_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.point_x        (point_x),
		.point_y        (point_y),
		.vertex_valid   (vertex_valid),
		.vertex_ready   (vertex_ready),
		.vertex_x       (vertex_x),
		.vertex_y       (vertex_y),
		.vertex_last    (vertex_last),
		.points_dropped (points_dropped)
	);

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid && vertex_ready && vertex_last) |=> !vertex_valid)
		else $error("vertex after last vertex of run");

	a_full_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && point_ready && sts.full) |=> sts.ovf)
		else $error("point past capacity not flagged");

	a_no_load_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && point_ready && set_last) |=> !point_ready)
		else $error("point taken during hull run");

endmodule
